// ===== src/idfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idfl_pkg
// Shared types and codes for the free-list ID allocator.
// ----------------------------------------------------------------------------

package idfl_pkg;

  // Request kinds carried on the slave-side tuser
  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_FREE  = 3'd2,
    REQ_FIND  = 3'd3,
    REQ_CHECK = 3'd4
  } req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_HOLD
  } state_e;

  localparam int REQ_W  = 3;
  localparam int ARG_W  = 16;
  localparam int RID_W  = 7;
  localparam int OUT_DW = 8;

endpackage

// ===== src/id_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_free_list_allocator
// Hands out IDs 1..NUM_IDS from a linked free list kept in a link memory.
// ----------------------------------------------------------------------------
// Each accepted word is one request (tuser: kind, tdata: ID argument) and
// yields exactly one result word (tdata: ID, tuser: ok flag). The link table
// lives in a single synchronous memory with a registered read; the list
// head sits in a register. For alloc, free and check requests the memory
// read issues at acceptance, any write-back and the result follow in the
// next cycle. Find walks the memory one entry per cycle and stops at the
// lowest allocated ID, or after the last entry when nothing is allocated.
// Init rewrites the whole chain, one entry per cycle. After reset the same
// rebuild pass runs with s_axis_tready low and produces no result word. Only
// one request is in work at a time; the output register lets the next
// request in while a finished result still waits for m_axis_tready.
// ----------------------------------------------------------------------------

module id_free_list_allocator #(
  parameter int NUM_IDS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] id_arg
  input  logic [2:0] s_axis_tuser,    // [2:0] req_type
  // Result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [6:0] result_id, [7] zero pad
  output logic       m_axis_tuser     // [0] ok
);

  // Entry values span 0 (tail) .. NUM_IDS + 1 (allocated marker)
  localparam int IdW  = $clog2(NUM_IDS + 2);
  localparam int AddrW = $clog2(NUM_IDS + 1);
  localparam int RidW = idfl_pkg::RID_W;
  localparam int ArgW = idfl_pkg::ARG_W;
  localparam logic [IdW-1:0]   AllocCode = IdW'(NUM_IDS + 1);
  localparam logic [IdW-1:0]   TailCode  = '0;
  localparam logic [IdW-1:0]   NumIdsW   = IdW'(NUM_IDS);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(NUM_IDS);
  localparam logic [AddrW-1:0] FirstAddr = AddrW'(1);
  localparam logic [ArgW-1:0]  NumIdsArg = ArgW'(NUM_IDS);

  idfl_pkg::state_e state_q, state_d;

  // Link memory
  logic [IdW-1:0]   mem_q [NUM_IDS+1];
  logic [IdW-1:0]   mem_rdata_q;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [IdW-1:0]   mem_wdata;

  // Request context
  logic [2:0]       req_q;
  logic [AddrW-1:0] id_q;
  logic             range_ok_q;
  logic             fill_reply_q, fill_reply_d;
  logic [AddrW-1:0] fill_addr_q, fill_addr_d;
  logic [AddrW-1:0] scan_addr_q, scan_addr_d;
  logic [IdW-1:0]   head_q, head_d;

  // Output register and pending slot
  logic             m_valid_q;
  logic [RidW-1:0]  m_rid_q;
  logic             m_ok_q;
  logic [RidW-1:0]  pend_rid_q;
  logic             pend_ok_q;

  logic             accept;
  logic             out_free;
  logic             head_ok;
  logic             hit;
  logic             arg_in_range;
  logic             res_valid;
  logic [RidW-1:0]  res_rid;
  logic             res_ok;

  assign s_axis_tready = (state_q == idfl_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign head_ok       = (head_q != TailCode) && (head_q <= NumIdsW);
  assign hit           = (mem_rdata_q == AllocCode);
  assign arg_in_range  = (s_axis_tdata != '0) && (s_axis_tdata <= NumIdsArg);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_rid_q};
  assign m_axis_tuser  = m_ok_q;

  // Next state: a finished result leaves for IDLE, or HOLD if the output is busy
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idfl_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == idfl_pkg::REQ_INIT) begin
            state_d = idfl_pkg::ST_FILL;
          end else if (s_axis_tuser == idfl_pkg::REQ_FIND) begin
            state_d = idfl_pkg::ST_SCAN;
          end else begin
            state_d = idfl_pkg::ST_EXEC;
          end
        end
      end
      idfl_pkg::ST_FILL: begin
        if (fill_addr_q == LastAddr) begin
          state_d = (res_valid && !out_free) ? idfl_pkg::ST_HOLD : idfl_pkg::ST_IDLE;
        end
      end
      idfl_pkg::ST_EXEC, idfl_pkg::ST_SCAN: begin
        if (res_valid) begin
          state_d = out_free ? idfl_pkg::ST_IDLE : idfl_pkg::ST_HOLD;
        end
      end
      idfl_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = idfl_pkg::ST_IDLE;
        end
      end
      default: state_d = idfl_pkg::ST_IDLE;
    endcase
  end

  // Memory control, list head and result per state
  always_comb begin
    mem_re       = 1'b0;
    mem_raddr    = FirstAddr;
    mem_we       = 1'b0;
    mem_waddr    = fill_addr_q;
    mem_wdata    = TailCode;
    head_d       = head_q;
    fill_addr_d  = fill_addr_q;
    fill_reply_d = fill_reply_q;
    scan_addr_d  = scan_addr_q;
    res_valid    = 1'b0;
    res_rid      = '0;
    res_ok       = 1'b0;
    unique case (state_q)
      idfl_pkg::ST_IDLE: begin
        if (accept) begin
          // Issue the read the request needs; the data lands next cycle
          if (s_axis_tuser == idfl_pkg::REQ_ALLOC) begin
            mem_re    = 1'b1;
            mem_raddr = head_q[AddrW-1:0];
          end else if (s_axis_tuser == idfl_pkg::REQ_FREE ||
                       s_axis_tuser == idfl_pkg::REQ_CHECK) begin
            mem_re    = 1'b1;
            mem_raddr = s_axis_tdata[AddrW-1:0];
          end else if (s_axis_tuser == idfl_pkg::REQ_FIND) begin
            mem_re    = 1'b1;
            mem_raddr = FirstAddr;
          end
          scan_addr_d = FirstAddr;
          if (s_axis_tuser == idfl_pkg::REQ_INIT) begin
            fill_addr_d  = FirstAddr;
            fill_reply_d = 1'b1;
          end
        end
      end
      idfl_pkg::ST_FILL: begin
        // Rebuild the chain: entry i points to i+1, the last one is the tail
        mem_we    = 1'b1;
        mem_waddr = fill_addr_q;
        mem_wdata = (fill_addr_q == LastAddr) ? TailCode : (IdW'(fill_addr_q) + IdW'(1));
        if (fill_addr_q == LastAddr) begin
          head_d       = IdW'(1);
          fill_reply_d = 1'b0;
          res_valid    = fill_reply_q;
          res_ok       = 1'b1;
        end else begin
          fill_addr_d = fill_addr_q + AddrW'(1);
        end
      end
      idfl_pkg::ST_EXEC: begin
        res_valid = 1'b1;
        if (req_q == idfl_pkg::REQ_ALLOC) begin
          // Pop: head advances to the popped entry's link, entry marked taken
          if (head_ok) begin
            mem_we    = 1'b1;
            mem_waddr = head_q[AddrW-1:0];
            mem_wdata = AllocCode;
            head_d    = mem_rdata_q;
            res_rid   = RidW'(head_q);
            res_ok    = 1'b1;
          end
        end else if (req_q == idfl_pkg::REQ_FREE) begin
          // Push only an allocated, in-range ID
          if (range_ok_q && hit) begin
            mem_we    = 1'b1;
            mem_waddr = id_q;
            mem_wdata = head_q;
            head_d    = IdW'(id_q);
            res_ok    = 1'b1;
          end
        end else if (req_q == idfl_pkg::REQ_CHECK) begin
          res_ok = range_ok_q && hit;
        end
      end
      idfl_pkg::ST_SCAN: begin
        if (hit) begin
          res_valid = 1'b1;
          res_rid   = RidW'(scan_addr_q);
          res_ok    = 1'b1;
        end else if (scan_addr_q == LastAddr) begin
          res_valid = 1'b1;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = scan_addr_q + AddrW'(1);
          scan_addr_d = scan_addr_q + AddrW'(1);
        end
      end
      idfl_pkg::ST_HOLD: begin
        res_valid = 1'b0;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // Link memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Request context
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= s_axis_tuser;
      id_q       <= s_axis_tdata[AddrW-1:0];
      range_ok_q <= arg_in_range;
    end
    if (res_valid && !out_free) begin
      pend_rid_q <= res_rid;
      pend_ok_q  <= res_ok;
    end
  end

  // Control state; start with the rebuild pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= idfl_pkg::ST_FILL;
      fill_addr_q  <= FirstAddr;
      fill_reply_q <= 1'b0;
      scan_addr_q  <= FirstAddr;
      head_q       <= IdW'(1);
      m_valid_q    <= 1'b0;
      m_rid_q      <= '0;
      m_ok_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_addr_q  <= fill_addr_d;
      fill_reply_q <= fill_reply_d;
      scan_addr_q  <= scan_addr_d;
      head_q       <= head_d;
      // Load the output word when the slot frees, else drop it once taken
      if (res_valid && out_free) begin
        m_valid_q <= 1'b1;
        m_rid_q   <= res_rid;
        m_ok_q    <= res_ok;
      end else if (state_q == idfl_pkg::ST_HOLD && out_free) begin
        m_valid_q <= 1'b1;
        m_rid_q   <= pend_rid_q;
        m_ok_q    <= pend_ok_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // The table is only written while a request is in work or the chain is rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idfl_pkg::ST_IDLE || state_q == idfl_pkg::ST_HOLD) |-> !mem_we)
    else $error("link memory written outside a request");

  // The head points at a valid ID or the tail once the chain is built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != idfl_pkg::ST_FILL |-> head_q <= NumIdsW)
    else $error("free-list head out of range");

  // A held result exists only behind a still occupied output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idfl_pkg::ST_HOLD |-> m_valid_q)
    else $error("result held with an empty output register");

  // The scan stays within IDs 1..NUM_IDS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idfl_pkg::ST_SCAN |-> (scan_addr_q != '0) && (scan_addr_q <= LastAddr))
    else $error("scan address out of range");

endmodule

// ===== bench/id_free_list_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_free_list_allocator_test
// Self-checking bench for the linked free-list ID allocator.
// ----------------------------------------------------------------------------
// Drives request words (init, alloc, free, find, check and the unused kinds)
// into the slave side and collects one result word per request on the master
// side. A tracker class keeps its own copy of the link table, predicts each
// result when a request is accepted and compares every result word field by
// field. A short directed opening hits the corner cases; a long random run
// follows in segments that grow, shrink, mix or exhaust the pool. Both sides
// take random idle bursts, the receiver once holds off long enough to back
// the block up, and the sender once waits mid-run for every outstanding result.
// ----------------------------------------------------------------------------

module id_free_list_allocator_test;

  localparam int NUM_IDS       = 64;
  localparam int REQ_W         = idfl_pkg::REQ_W;
  localparam int ARG_W         = idfl_pkg::ARG_W;
  localparam int RID_W         = idfl_pkg::RID_W;
  localparam int OUT_DW        = idfl_pkg::OUT_DW;
  // Link table codes: end of the free chain and "ID is handed out"
  localparam logic [RID_W-1:0] TAIL_MARK  = '0;
  localparam logic [RID_W-1:0] ALLOC_MARK = RID_W'(NUM_IDS + 1);
  // Request kinds the block does not define; they must answer "nothing done"
  localparam int FIRST_UNKNOWN = idfl_pkg::REQ_CHECK + 1;
  localparam int KIND_TOP      = (1 << REQ_W) - 1;

  localparam int RANDOM_ITEMS  = 1125;
  localparam int QUIET_TAIL    = 150;   // last words go without any idling
  localparam int HOLD_AT       = 300;   // word index that starts the long stall
  localparam int SETTLE_AT     = 650;   // word index that waits for a drain
  localparam int LONG_HOLD     = 120;   // receiver stall length, in cycles
  localparam int RUN_LIMIT_NS  = 6_000_000;

  typedef enum {SEG_GROW, SEG_SHRINK, SEG_MIXED, SEG_EXHAUST} segment_e;

  // --------------------------------------------------------------------------
  // Tracker: own link table plus the queue of results owed by the block
  // --------------------------------------------------------------------------
  class id_pool_tracker;
    logic [RID_W-1:0] links [0:NUM_IDS];
    logic [RID_W:0]   owed_responses [$];   // {result_id, ok}
    int errors;
    int n_req, n_grant, n_empty, n_freed, n_rejected;
    int n_found, n_valid, n_unknown, n_init;

    function new();
      errors = 0;
      n_req = 0; n_grant = 0; n_empty = 0; n_freed = 0; n_rejected = 0;
      n_found = 0; n_valid = 0; n_unknown = 0; n_init = 0;
      relink_all();
    endfunction

    function void relink_all();
      for (int i = 0; i < NUM_IDS; i++) links[i] = RID_W'(i + 1);
      links[NUM_IDS] = TAIL_MARK;
    endfunction

    function bit in_pool(int unsigned v);
      return v >= 1 && v <= NUM_IDS;
    endfunction

    function int pending();
      return owed_responses.size();
    endfunction

    // Random ID that is handed out right now, 0 when none is
    function logic [ARG_W-1:0] any_allocated();
      int taken [$];
      for (int i = 1; i <= NUM_IDS; i++) if (links[i] == ALLOC_MARK) taken.push_back(i);
      if (taken.size() == 0) return '0;
      return ARG_W'(taken[$urandom_range(taken.size() - 1, 0)]);
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [ARG_W-1:0] arg);
      logic [RID_W-1:0] head;
      logic [RID_W-1:0] rid;
      logic             ok;
      rid = '0;
      ok  = 1'b0;
      n_req++;
      case (kind)
        idfl_pkg::REQ_INIT: begin
          relink_all();
          ok = 1'b1;
          n_init++;
        end
        idfl_pkg::REQ_ALLOC: begin
          head = links[0];
          if (head != TAIL_MARK && in_pool(head)) begin
            rid = head;
            links[0] = links[head];
            links[head] = ALLOC_MARK;
            ok = 1'b1;
            n_grant++;
          end else begin
            n_empty++;
          end
        end
        idfl_pkg::REQ_FREE: begin
          // push back on the head only if it is really out; else ignore
          if (in_pool(arg) && links[arg] == ALLOC_MARK) begin
            links[arg] = links[0];
            links[0] = arg[RID_W-1:0];
            ok = 1'b1;
            n_freed++;
          end else begin
            n_rejected++;
          end
        end
        idfl_pkg::REQ_FIND: begin
          for (int i = 1; i <= NUM_IDS; i++) begin
            if (links[i] == ALLOC_MARK) begin
              rid = RID_W'(i);
              ok = 1'b1;
              break;
            end
          end
          if (ok) n_found++;
        end
        idfl_pkg::REQ_CHECK: begin
          if (in_pool(arg) && links[arg] == ALLOC_MARK) begin
            ok = 1'b1;
            n_valid++;
          end
        end
        default: n_unknown++;
      endcase
      owed_responses.push_back({rid, ok});
    endfunction

    function void check_response(logic [RID_W-1:0] rid, logic ok);
      logic [RID_W:0] want;
      if (owed_responses.size() == 0) begin
        $error("result word with no request outstanding: result_id %0d, ok %0d", rid, ok);
        errors++;
        return;
      end
      want = owed_responses.pop_front();
      if (want[RID_W:1] !== rid) begin
        $error("result_id mismatch: expected %0d, actual %0d", want[RID_W:1], rid);
        errors++;
      end
      if (want[0] !== ok) begin
        $error("ok mismatch: expected %0d, actual %0d", want[0], ok);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ARG_W-1:0]   s_axis_tdata;    // [15:0] id_arg
  logic [REQ_W-1:0]   s_axis_tuser;    // [2:0] req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_DW-1:0]  m_axis_tdata;    // [6:0] result_id, [7] zero pad
  logic               m_axis_tuser;    // [0] ok

  id_free_list_allocator #(
    .NUM_IDS(NUM_IDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  id_pool_tracker book;

  // Knobs for the sender and the receiver
  bit quiet;             // no idling on either side
  bit backpressure_req;  // sender asks the receiver for one long stall
  int gap_pct;           // sender idle odds for the current segment

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: sample at the rising edge, check in arrival order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.check_response(m_axis_tdata[RID_W-1:0], m_axis_tuser);
  end

  // Receiver ready: random stall bursts, one long requested stall, none when
  // quiet. The stall length is counted here, one step per falling edge.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (backpressure_req) begin
        backpressure_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(7, 0) == 0) begin
        hold_left = $urandom_range(14, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one word, hold it until accepted, then maybe idle for a burst.
  // Always returns on a falling edge.
  task automatic issue(input logic [REQ_W-1:0] kind, input logic [ARG_W-1:0] arg);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= arg;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(kind, arg);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99, 0) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(negedge clk_i);
    end
  endtask

  function automatic logic [REQ_W-1:0] pick_kind(segment_e seg);
    int r;
    int wa, wf, wc, wd, wi;
    r = $urandom_range(99, 0);
    case (seg)
      SEG_EXHAUST: return idfl_pkg::REQ_ALLOC;
      SEG_GROW:    begin wa = 60; wf = 15; wc = 12; wd = 6; wi = 2; end
      SEG_SHRINK:  begin wa = 15; wf = 60; wc = 12; wd = 6; wi = 2; end
      default:     begin wa = 38; wf = 35; wc = 14; wd = 6; wi = 2; end
    endcase
    if (r < wa) return idfl_pkg::REQ_ALLOC;
    r -= wa;
    if (r < wf) return idfl_pkg::REQ_FREE;
    r -= wf;
    if (r < wc) return idfl_pkg::REQ_CHECK;
    r -= wc;
    if (r < wd) return idfl_pkg::REQ_FIND;
    r -= wd;
    if (r < wi) return idfl_pkg::REQ_INIT;
    return REQ_W'($urandom_range(KIND_TOP, FIRST_UNKNOWN));
  endfunction

  // Free and check mostly aim at live IDs or the pool range; the rest is noise
  function automatic logic [ARG_W-1:0] pick_arg(logic [REQ_W-1:0] kind);
    int r;
    r = $urandom_range(99, 0);
    if (kind != idfl_pkg::REQ_FREE && kind != idfl_pkg::REQ_CHECK)
      return ARG_W'($urandom_range(16'hFFFF, 0));
    if (r < 50 && book.any_allocated() != 0) return book.any_allocated();
    if (r < 88) return ARG_W'($urandom_range(NUM_IDS + 1, 0));
    return ARG_W'($urandom_range(16'hFFFF, 0));
  endfunction

  initial begin : stimulus
    segment_e         seg;
    int               seg_left;
    int               issued;
    logic [REQ_W-1:0] kind;
    book = new();
    quiet = 1'b0;
    backpressure_req = 1'b0;
    gap_pct = 20;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = idfl_pkg::REQ_INIT;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    // the block runs its rebuild pass now; issue just waits on tready
    rst_ni <= 1'b1;

    // Directed opening: empty find, bad frees and checks, unknown kinds,
    // LIFO reuse, double free, re-init
    issue(idfl_pkg::REQ_FIND,  16'h0000);
    issue(idfl_pkg::REQ_CHECK, 16'h0000);
    issue(idfl_pkg::REQ_CHECK, 16'h0001);
    issue(idfl_pkg::REQ_FREE,  16'h0000);
    issue(idfl_pkg::REQ_FREE,  16'h0001);
    issue(idfl_pkg::REQ_FREE,  ARG_W'(NUM_IDS + 1));
    issue(idfl_pkg::REQ_FREE,  16'hFFFF);
    for (int k = FIRST_UNKNOWN; k <= KIND_TOP; k++) issue(REQ_W'(k), 16'hFFFF);
    issue(idfl_pkg::REQ_ALLOC, 16'hFFFF);
    issue(idfl_pkg::REQ_ALLOC, 16'h0000);
    issue(idfl_pkg::REQ_CHECK, 16'h0001);
    issue(idfl_pkg::REQ_CHECK, ARG_W'(NUM_IDS));
    issue(idfl_pkg::REQ_FIND,  16'h0000);
    issue(idfl_pkg::REQ_FREE,  16'h0001);
    issue(idfl_pkg::REQ_FREE,  16'h0001);
    issue(idfl_pkg::REQ_FIND,  16'h0000);
    issue(idfl_pkg::REQ_ALLOC, 16'h0000);
    issue(idfl_pkg::REQ_CHECK, 16'hFFFF);
    issue(idfl_pkg::REQ_INIT,  16'h5555);
    issue(idfl_pkg::REQ_FIND,  16'hAAAA);
    issue(idfl_pkg::REQ_ALLOC, 16'h0000);

    // Random run in segments; open by draining the pool past empty
    issued = 0;
    seg = SEG_EXHAUST;
    seg_left = NUM_IDS + 4;
    while (issued < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        case ($urandom_range(9, 0))
          0:       seg = SEG_EXHAUST;
          1, 2, 3: seg = SEG_GROW;
          4, 5, 6: seg = SEG_SHRINK;
          default: seg = SEG_MIXED;
        endcase
        seg_left = (seg == SEG_EXHAUST) ? NUM_IDS + 4 : $urandom_range(60, 20);
        case ($urandom_range(3, 0))
          0:       gap_pct = 0;
          1:       gap_pct = 40;
          default: gap_pct = 12;
        endcase
      end
      if (issued == HOLD_AT) backpressure_req = 1'b1;
      if (issued == SETTLE_AT) begin
        // pause until every owed result is back
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (book.pending() != 0);
      end
      quiet = (issued >= RANDOM_ITEMS - QUIET_TAIL);
      kind = pick_kind(seg);
      issue(kind, pick_arg(kind));
      issued++;
      seg_left--;
    end

    // Drain, then give a full-length find or init time to show stray words
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (book.pending() != 0);
    repeat (NUM_IDS + 8) @(negedge clk_i);

    $display("Covered %0d requests: %0d grants, %0d empty-pool allocs, %0d frees, %0d ignored frees.",
             book.n_req, book.n_grant, book.n_empty, book.n_freed, book.n_rejected);
    $display("Finds that hit %0d, live checks %0d, unknown kinds %0d, re-inits %0d.",
             book.n_found, book.n_valid, book.n_unknown, book.n_init);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $error("run did not finish in time, %0d results still owed", book.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/idfl_pkg.sv
src/id_free_list_allocator.sv
bench/id_free_list_allocator_test.sv
